### sv/nvpt_pkg.sv
// Shared types, codes and character classes for the name/value pair tokenizer.
`timescale 1ns / 1ps

package nvpt_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned RoleW   = 3;
  localparam int unsigned StatusW = 2;

  // Parser state, one-hot
  typedef enum logic [6:0] {
    MODE_BEFORE_NAME = 7'b0000001,
    MODE_NAME        = 7'b0000010,
    MODE_AFTER_NAME  = 7'b0000100,
    MODE_AFTER_EQ    = 7'b0001000,
    MODE_VALUE       = 7'b0010000,
    MODE_QUOTED      = 7'b0100000,
    MODE_IGNORE      = 7'b1000000
  } mode_e;

  localparam logic [RoleW-1:0] ROLE_SKIP  = 3'd0;
  localparam logic [RoleW-1:0] ROLE_NAME  = 3'd1;
  localparam logic [RoleW-1:0] ROLE_EQ    = 3'd2;
  localparam logic [RoleW-1:0] ROLE_VALUE = 3'd3;
  localparam logic [RoleW-1:0] ROLE_QUOTE = 3'd4;

  localparam logic [StatusW-1:0] ST_CONT = 2'd0;
  localparam logic [StatusW-1:0] ST_PAIR = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD  = 2'd2;
  localparam logic [StatusW-1:0] ST_END  = 2'd3;

  localparam logic [ChW-1:0] CH_NUL    = 8'h00;
  localparam logic [ChW-1:0] CH_TAB    = 8'h09;
  localparam logic [ChW-1:0] CH_LF     = 8'h0A;
  localparam logic [ChW-1:0] CH_CR     = 8'h0D;
  localparam logic [ChW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ChW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [ChW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [ChW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ChW-1:0] CH_SEMI   = 8'h3B;
  localparam logic [ChW-1:0] CH_EQ     = 8'h3D;

  typedef struct packed {
    logic [ChW-1:0]     ch;
    logic [RoleW-1:0]   role;
    logic [StatusW-1:0] status;
  } result_t;

  function automatic logic is_sep(input logic [ChW-1:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_SPACE) ||
           (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_quote(input logic [ChW-1:0] c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

endpackage

### sv/nvpt_parser.sv
// Parser state register and per-character classification logic.
`timescale 1ns / 1ps

module nvpt_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [nvpt_pkg::ChW-1:0] ch_i,
  output nvpt_pkg::result_t      res_o,
  output nvpt_pkg::mode_e        mode_o
);

  nvpt_pkg::mode_e mode_q, mode_d;
  logic            dquote_q, dquote_d;
  logic [nvpt_pkg::RoleW-1:0]   role;
  logic [nvpt_pkg::StatusW-1:0] status;
  logic            sep, eq;

  assign sep = nvpt_pkg::is_sep(ch_i);
  assign eq  = (ch_i == nvpt_pkg::CH_EQ);

  always_comb begin
    mode_d   = mode_q;
    dquote_d = dquote_q;
    role     = nvpt_pkg::ROLE_SKIP;
    status   = nvpt_pkg::ST_CONT;
    if (ch_i == nvpt_pkg::CH_NUL) begin
      // terminator completes a pending value, otherwise just ends the string
      status   = ((mode_q == nvpt_pkg::MODE_AFTER_EQ) || (mode_q == nvpt_pkg::MODE_VALUE) ||
                  (mode_q == nvpt_pkg::MODE_QUOTED)) ? nvpt_pkg::ST_PAIR : nvpt_pkg::ST_END;
      mode_d   = nvpt_pkg::MODE_BEFORE_NAME;
      dquote_d = 1'b0;
    end else begin
      case (mode_q)
        nvpt_pkg::MODE_NAME: begin
          if (eq) begin
            role   = nvpt_pkg::ROLE_EQ;
            mode_d = nvpt_pkg::MODE_AFTER_EQ;
          end else if (sep) begin
            mode_d = nvpt_pkg::MODE_AFTER_NAME;
          end else begin
            role = nvpt_pkg::ROLE_NAME;
          end
        end
        nvpt_pkg::MODE_AFTER_NAME: begin
          if (eq) begin
            role   = nvpt_pkg::ROLE_EQ;
            mode_d = nvpt_pkg::MODE_AFTER_EQ;
          end else if (!sep) begin
            status = nvpt_pkg::ST_BAD;
            mode_d = nvpt_pkg::MODE_IGNORE;
          end
        end
        nvpt_pkg::MODE_AFTER_EQ: begin
          if (sep) begin
            mode_d = nvpt_pkg::MODE_AFTER_EQ;
          end else if (eq) begin
            // second '=' closes an empty value
            status = nvpt_pkg::ST_PAIR;
            mode_d = nvpt_pkg::MODE_BEFORE_NAME;
          end else if (nvpt_pkg::is_quote(ch_i)) begin
            role     = nvpt_pkg::ROLE_QUOTE;
            dquote_d = (ch_i == nvpt_pkg::CH_DQUOTE);
            mode_d   = nvpt_pkg::MODE_QUOTED;
          end else begin
            role   = nvpt_pkg::ROLE_VALUE;
            mode_d = nvpt_pkg::MODE_VALUE;
          end
        end
        nvpt_pkg::MODE_VALUE: begin
          if (eq || sep) begin
            status = nvpt_pkg::ST_PAIR;
            mode_d = nvpt_pkg::MODE_BEFORE_NAME;
          end else begin
            role = nvpt_pkg::ROLE_VALUE;
          end
        end
        nvpt_pkg::MODE_QUOTED: begin
          if (ch_i == (dquote_q ? nvpt_pkg::CH_DQUOTE : nvpt_pkg::CH_SQUOTE)) begin
            role   = nvpt_pkg::ROLE_QUOTE;
            status = nvpt_pkg::ST_PAIR;
            mode_d = nvpt_pkg::MODE_BEFORE_NAME;
          end else begin
            role = nvpt_pkg::ROLE_VALUE;
          end
        end
        nvpt_pkg::MODE_IGNORE: begin
          mode_d = nvpt_pkg::MODE_IGNORE;
        end
        default: begin
          if (eq) begin
            role   = nvpt_pkg::ROLE_EQ;
            mode_d = nvpt_pkg::MODE_AFTER_EQ;
          end else if (sep) begin
            mode_d = nvpt_pkg::MODE_BEFORE_NAME;
          end else begin
            role   = nvpt_pkg::ROLE_NAME;
            mode_d = nvpt_pkg::MODE_NAME;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= nvpt_pkg::MODE_BEFORE_NAME;
      dquote_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      dquote_q <= dquote_d;
    end
  end

  assign res_o.ch     = ch_i;
  assign res_o.role   = role;
  assign res_o.status = status;
  assign mode_o       = mode_q;

endmodule

### sv/name_value_pair_tokenizer_core.sv
// Top level: input register, parser and result register of the pair tokenizer.
//
//   channel | signals                                 | dir
//   in      | in_valid_i, in_ready_o, ch_i            | word in
//   out     | out_valid_o, out_ready_i, ch_out_o,     | word out
//           | role_o, status_o                        |
//
// One word per cycle sustained while the output is not stalled; a word goes
// from the input register to the result register, and the parser state
// advances as it moves, so the state loop through one register sets the rate.
// Reset clears both valid flags and puts the parser before a name.
// A stalled output holds its word; the input register keeps taking words
// until it too is full.
`timescale 1ns / 1ps

module name_value_pair_tokenizer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nvpt_pkg::ChW-1:0]     ch_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [nvpt_pkg::ChW-1:0]     ch_out_o,
  output logic [nvpt_pkg::RoleW-1:0]   role_o,
  output logic [nvpt_pkg::StatusW-1:0] status_o
);

  logic                     in_vld_q;
  logic [nvpt_pkg::ChW-1:0] in_ch_q;
  logic                     out_vld_q;
  nvpt_pkg::result_t        out_q;
  nvpt_pkg::result_t        res;
  nvpt_pkg::mode_e          mode;
  logic                     out_free, step;

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_ch_q <= ch_i;
    if (step) out_q <= res;
  end

  nvpt_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (in_ch_q),
    .res_o  (res),
    .mode_o (mode)
  );

  assign out_valid_o = out_vld_q;
  assign ch_out_o    = out_q.ch;
  assign role_o      = out_q.role;
  assign status_o    = out_q.status;

  // a terminator always leaves the parser before a name
  a_nul_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_ch_q == nvpt_pkg::CH_NUL) |=> (mode == nvpt_pkg::MODE_BEFORE_NAME))
    else $error("parser not reset by terminator");

  // end-of-string status only ever comes with the zero word, untagged
  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && status_o == nvpt_pkg::ST_END) |->
      (ch_out_o == nvpt_pkg::CH_NUL && role_o == nvpt_pkg::ROLE_SKIP))
    else $error("end status on non-terminator");

  // a held input word is not dropped while the output stalls
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(in_ch_q)))
    else $error("input word lost during stall");

  // ignore mode is entered only through a malformed flag
  a_ignore_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && mode != nvpt_pkg::MODE_IGNORE && res.status != nvpt_pkg::ST_BAD) |=>
      (mode != nvpt_pkg::MODE_IGNORE))
    else $error("ignore mode without malformed pair");

endmodule
